// ===== sv/gradient_profile_envelope_table_defines.svh =====
// assertion macros for the gradient envelope table
`ifndef GRADIENT_PROFILE_ENVELOPE_TABLE_DEFINES_SVH
`define GRADIENT_PROFILE_ENVELOPE_TABLE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define GPET_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpet check failed");
// next-cycle implication
`define GPET_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpet check failed");
`endif

// ===== sv/gpet_pkg.sv =====
// shared types and constants of the gradient envelope table
`timescale 1ns / 1ps
package gpet_pkg;
    localparam int MAX_SEGMENTS = 32;
    localparam int SLOT_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int PTS = 2 * MAX_SEGMENTS;
    localparam int PT_W = $clog2(PTS);
    localparam int PTC_W = $clog2(PTS + 1);
    localparam logic signed [10:0] GRADE_NONE = 11'sd1000;
    localparam logic signed [31:0] DIST_MAX = 32'sh7fffffff;
    localparam int QDEPTH = 2;
    // request and result word widths on the channels
    localparam int REQ_W = 46;
    localparam int RES_W = 46;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_CLEAR = 2'd1,
        OP_PRUNE = 2'd2,
        OP_RECALC = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        BATCH_IDLE = 2'd0,
        BATCH_OPEN = 2'd1,
        BATCH_DRAIN = 2'd2
    } batch_t;

    // command handed from the front part to the back part
    typedef struct packed {
        op_t kind;
        logic clip;
        logic clip_fin;
        logic signed [31:0] clip_pos;
        logic ins;
        logic signed [31:0] ins_start;
        logic signed [31:0] ins_end;
        logic signed [10:0] ins_grade;
        logic ins2;
        logic signed [31:0] ins2_start;
        logic signed [10:0] ins2_grade;
        logic signed [31:0] prune_pos;
    } cmd_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_CLIP_RD,
        BK_CLIP_WB,
        BK_INS,
        BK_OVF,
        BK_GATHER,
        BK_PICK,
        BK_SCAN_RD,
        BK_SCAN,
        BK_EMIT,
        BK_EMPTY,
        BK_PRUNE
    } back_t;
endpackage

// ===== sv/gpet_stream_if.sv =====
// valid/ready channel with a generic payload
`timescale 1ns / 1ps
interface gpet_stream_if #(parameter int W = 1);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== sv/gradient_profile_envelope_table.sv =====
// top level of the gradient envelope table
//  channel  dir  payload
//  req      in   opcode, position, grade_value, batch_last
//  res      out  point_position, point_grade, last_of_run, table_empty, overflow
// a load opening a batch first runs a clip sweep over the segment ram and then inserts, other loads only insert
// a load that closes a batch with a pending point also inserts that point as a second segment
// prune sweeps the segment ram entry by entry, clear empties the table as the command is taken
// recalculate runs a gather, pick, scan and emit pass per emitted boundary point, held by result stalls
// a waiting result stalls the back part; a two-entry command queue decouples the sides
// reset is asynchronous and empties the table; no clearing pass is needed
`timescale 1ns / 1ps
module gradient_profile_envelope_table (
    input logic clk,
    input logic rst_n,
    gpet_stream_if.sink req,
    gpet_stream_if.source res
);
    logic cmd_valid, cmd_ready;
    gpet_pkg::cmd_t cmd;

    gpet_front u_front (
        .clk, .rst_n,
        .in_valid(req.valid), .in_ready(req.ready),
        .opcode(req.data[45:44]), .position(req.data[43:12]),
        .grade_value(req.data[11:1]), .batch_last(req.data[0]),
        .cmd_valid, .cmd_ready, .cmd
    );

    gpet_back u_back (
        .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .res
    );
endmodule

// ===== sv/gpet_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module gpet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input logic clk,
    input logic we,
    input logic [$clog2(DEPTH)-1:0] waddr,
    input logic [WIDTH-1:0] wdata,
    input logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/gpet_front.sv =====
// front part: batch bookkeeping and command queue
`timescale 1ns / 1ps
module gpet_front (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    output logic in_ready,
    input logic [1:0] opcode,
    input logic signed [31:0] position,
    input logic signed [10:0] grade_value,
    input logic batch_last,
    output logic cmd_valid,
    input logic cmd_ready,
    output gpet_pkg::cmd_t cmd
);
    gpet_pkg::batch_t batch_reg, batch_next;
    logic pend_v_reg, pend_v_next;
    logic signed [31:0] pend_pos_reg, pend_pos_next;
    logic signed [10:0] pend_grade_reg, pend_grade_next;
    gpet_pkg::cmd_t q_reg [gpet_pkg::QDEPTH];
    logic [1:0] cnt_reg;
    logic wr_ptr_reg, rd_ptr_reg;
    gpet_pkg::cmd_t c;
    logic push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = q_reg[rd_ptr_reg];
    assign pop = cmd_valid && cmd_ready;

    always_comb
    begin
        logic st_open;
        logic pv;
        batch_next = batch_reg;
        pend_v_next = pend_v_reg;
        pend_pos_next = pend_pos_reg;
        pend_grade_next = pend_grade_reg;
        c = '0;
        c.kind = gpet_pkg::op_t'(opcode);
        c.clip_pos = position;
        c.prune_pos = position;
        st_open = 1'b0;
        pv = pend_v_reg;
        unique case (gpet_pkg::op_t'(opcode))
            gpet_pkg::OP_CLEAR:
            begin
                batch_next = gpet_pkg::BATCH_IDLE;
                pend_v_next = 1'b0;
            end
            gpet_pkg::OP_PRUNE, gpet_pkg::OP_RECALC:
            begin
            end
            default:
            begin
                if (batch_reg == gpet_pkg::BATCH_IDLE)
                begin
                    c.clip = 1'b1;
                    pv = 1'b0;
                    st_open = 1'b1;
                end
                else if (batch_reg == gpet_pkg::BATCH_OPEN)
                begin
                    st_open = 1'b1;
                end
                batch_next = batch_reg;
                if (st_open)
                begin
                    batch_next = gpet_pkg::BATCH_OPEN;
                    if (pv)
                    begin
                        c.ins = 1'b1;
                        c.ins_start = pend_pos_reg;
                        c.ins_end = position;
                        c.ins_grade = pend_grade_reg;
                        pv = 1'b0;
                    end
                    if (grade_value == gpet_pkg::GRADE_NONE)
                    begin
                        batch_next = gpet_pkg::BATCH_DRAIN;
                    end
                    else
                    begin
                        pv = 1'b1;
                        pend_pos_next = position;
                        pend_grade_next = grade_value;
                    end
                end
                if (batch_last)
                begin
                    if (pv)
                    begin
                        c.ins2 = 1'b1;
                        c.ins2_start = pend_pos_next;
                        c.ins2_grade = pend_grade_next;
                        pv = 1'b0;
                    end
                    batch_next = gpet_pkg::BATCH_IDLE;
                end
                pend_v_next = pv;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_reg <= gpet_pkg::BATCH_IDLE;
            pend_v_reg <= 1'b0;
            cnt_reg <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                batch_reg <= batch_next;
                pend_v_reg <= pend_v_next;
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= c;
            pend_pos_reg <= pend_pos_next;
            pend_grade_reg <= pend_grade_next;
        end
    end
endmodule

// ===== sv/gpet_back.sv =====
// back part: segment table update and envelope walk
`timescale 1ns / 1ps
`include "gradient_profile_envelope_table_defines.svh"
module gpet_back (
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    output logic cmd_ready,
    input gpet_pkg::cmd_t cmd,
    gpet_stream_if.source res
);
    localparam int SW = gpet_pkg::SLOT_W;
    localparam int NS = gpet_pkg::MAX_SEGMENTS;

    gpet_pkg::back_t st_reg, st_next;
    gpet_pkg::cmd_t cmd_reg;
    logic [NS-1:0] valid_reg;
    logic [SW-1:0] idx_reg;
    logic ovf_reg;
    logic ins_phase_reg;
    // last emitted boundary; next pick is the least value above it
    logic signed [31:0] lo_reg;
    logic lo_v_reg;
    logic signed [31:0] best_reg;
    logic best_v_reg;
    logic half_reg;
    logic signed [10:0] g_reg;
    logic [gpet_pkg::PTC_W-1:0] more_reg;
    logic res_v_reg;
    logic [45:0] res_reg;

    logic we;
    logic [SW-1:0] waddr, raddr;
    logic [31:0] ws, we_d;
    logic [10:0] wg;
    logic [31:0] rs, re;
    logic [10:0] rg;
    logic ws_en, we_en, wg_en;

    gpet_ram #(.WIDTH(32), .DEPTH(NS)) u_start (.clk, .we(ws_en), .waddr,
        .wdata(ws), .raddr, .rdata(rs));
    gpet_ram #(.WIDTH(32), .DEPTH(NS)) u_end (.clk, .we(we_en), .waddr,
        .wdata(we_d), .raddr, .rdata(re));
    gpet_ram #(.WIDTH(11), .DEPTH(NS)) u_grade (.clk, .we(wg_en), .waddr,
        .wdata(wg), .raddr, .rdata(rg));

    logic [SW-1:0] free_idx;
    logic free_any;
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SW'(i);
                free_any = 1'b1;
            end
        end
    end

    logic last_idx;
    assign last_idx = (idx_reg == SW'(NS - 1));
    assign cmd_ready = (st_reg == gpet_pkg::BK_IDLE) && !res_v_reg;
    assign res.valid = res_v_reg;
    assign res.data = res_reg;
    // sweeps read one entry ahead; gather reads each entry for both its start and its end
    assign raddr = (st_reg == gpet_pkg::BK_IDLE) ? '0 :
        (st_reg == gpet_pkg::BK_CLIP_WB || st_reg == gpet_pkg::BK_SCAN
         || st_reg == gpet_pkg::BK_PRUNE
         || (st_reg == gpet_pkg::BK_GATHER && half_reg)) ? idx_reg + SW'(1) : idx_reg;

    logic signed [31:0] cand;
    assign cand = half_reg ? $signed(re) : $signed(rs);
    logic signed [31:0] ins_s, ins_e;
    logic signed [10:0] ins_g;
    assign ins_s = ins_phase_reg ? cmd_reg.ins2_start : cmd_reg.ins_start;
    assign ins_e = ins_phase_reg ? gpet_pkg::DIST_MAX : cmd_reg.ins_end;
    assign ins_g = ins_phase_reg ? cmd_reg.ins2_grade : cmd_reg.ins_grade;
    logic ins_go;
    assign ins_go = (!ins_phase_reg && cmd_reg.ins) || (ins_phase_reg && cmd_reg.ins2);

    always_comb
    begin
        waddr = free_idx;
        ws = ins_s;
        we_d = ins_e;
        wg = ins_g;
        ws_en = 1'b0;
        we_en = 1'b0;
        wg_en = 1'b0;
        we = 1'b0;
        if (st_reg == gpet_pkg::BK_INS && free_any && ins_go)
        begin
            we = 1'b1;
            ws_en = 1'b1;
            we_en = 1'b1;
            wg_en = 1'b1;
        end
        if (st_reg == gpet_pkg::BK_CLIP_WB && valid_reg[idx_reg]
            && !($signed(rs) > cmd_reg.clip_pos) && ($signed(re) > cmd_reg.clip_pos))
        begin
            waddr = idx_reg;
            we_d = cmd_reg.clip_pos;
            we_en = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            gpet_pkg::BK_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    unique case (cmd.kind)
                        gpet_pkg::OP_LOAD:
                            st_next = cmd.clip ? gpet_pkg::BK_CLIP_RD :
                                gpet_pkg::BK_INS;
                        gpet_pkg::OP_RECALC:
                            st_next = (valid_reg == '0) ? gpet_pkg::BK_EMPTY :
                                gpet_pkg::BK_GATHER;
                        gpet_pkg::OP_PRUNE: st_next = gpet_pkg::BK_PRUNE;
                        default: st_next = gpet_pkg::BK_IDLE;
                    endcase
                end
            end
            gpet_pkg::BK_CLIP_RD: st_next = gpet_pkg::BK_CLIP_WB;
            gpet_pkg::BK_CLIP_WB:
                st_next = last_idx ? gpet_pkg::BK_INS : gpet_pkg::BK_CLIP_WB;
            gpet_pkg::BK_INS:
            begin
                if (!ins_phase_reg && cmd_reg.ins2)
                    st_next = gpet_pkg::BK_INS;
                else
                    st_next = gpet_pkg::BK_OVF;
            end
            gpet_pkg::BK_OVF: st_next = gpet_pkg::BK_IDLE;
            gpet_pkg::BK_GATHER:
                st_next = (last_idx && half_reg) ? gpet_pkg::BK_PICK :
                    gpet_pkg::BK_GATHER;
            gpet_pkg::BK_PICK:
                st_next = best_v_reg ? gpet_pkg::BK_SCAN : gpet_pkg::BK_IDLE;
            gpet_pkg::BK_SCAN:
                st_next = last_idx ? gpet_pkg::BK_EMIT : gpet_pkg::BK_SCAN;
            gpet_pkg::BK_EMIT:
            begin
                if (res_v_reg)
                    st_next = gpet_pkg::BK_EMIT;
                else if (more_reg == '0)
                    st_next = gpet_pkg::BK_IDLE;
                else
                    st_next = gpet_pkg::BK_GATHER;
            end
            gpet_pkg::BK_EMPTY:
                st_next = !res_v_reg ? gpet_pkg::BK_IDLE : gpet_pkg::BK_EMPTY;
            gpet_pkg::BK_PRUNE:
                st_next = last_idx ? gpet_pkg::BK_IDLE : gpet_pkg::BK_PRUNE;
            default: st_next = gpet_pkg::BK_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= gpet_pkg::BK_IDLE;
            valid_reg <= '0;
            res_v_reg <= 1'b0;
            idx_reg <= '0;
            half_reg <= 1'b0;
            ins_phase_reg <= 1'b0;
            ovf_reg <= 1'b0;
            lo_v_reg <= 1'b0;
            best_v_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (res_v_reg && res.ready)
            begin
                res_v_reg <= 1'b0;
            end
            unique case (st_reg)
                gpet_pkg::BK_IDLE:
                begin
                    idx_reg <= '0;
                    half_reg <= 1'b0;
                    ins_phase_reg <= 1'b0;
                    ovf_reg <= 1'b0;
                    lo_v_reg <= 1'b0;
                    best_v_reg <= 1'b0;
                    if (cmd_valid && cmd_ready)
                    begin
                        if (cmd.kind == gpet_pkg::OP_CLEAR)
                            valid_reg <= '0;
                        if (cmd.kind == gpet_pkg::OP_PRUNE)
                            idx_reg <= '0;
                    end
                end
                gpet_pkg::BK_CLIP_RD: idx_reg <= idx_reg;
                gpet_pkg::BK_CLIP_WB:
                begin
                    if (valid_reg[idx_reg] && $signed(rs) > cmd_reg.clip_pos)
                        valid_reg[idx_reg] <= 1'b0;
                    idx_reg <= idx_reg + SW'(1);
                end
                gpet_pkg::BK_INS:
                begin
                    if (ins_go)
                    begin
                        if (free_any)
                            valid_reg[free_idx] <= 1'b1;
                        else
                            ovf_reg <= 1'b1;
                    end
                    ins_phase_reg <= 1'b1;
                end
                gpet_pkg::BK_OVF:
                begin
                    if (ovf_reg)
                    begin
                        res_v_reg <= 1'b1;
                        res_reg <= {32'd0, 11'd0, 1'b1, 1'b0, 1'b1};
                    end
                end
                gpet_pkg::BK_GATHER:
                begin
                    // least boundary above the last emitted one
                    if (valid_reg[idx_reg] && (!lo_v_reg || cand > lo_reg)
                        && (!best_v_reg || cand < best_reg))
                    begin
                        best_reg <= cand;
                        best_v_reg <= 1'b1;
                    end
                    if (half_reg)
                        idx_reg <= idx_reg + SW'(1);
                    half_reg <= !half_reg;
                end
                gpet_pkg::BK_PICK:
                begin
                    lo_reg <= best_reg;
                    lo_v_reg <= 1'b1;
                    g_reg <= gpet_pkg::GRADE_NONE;
                    more_reg <= '0;
                    idx_reg <= '0;
                end
                gpet_pkg::BK_SCAN:
                begin
                    if (valid_reg[idx_reg])
                    begin
                        if (!($signed(rs) > lo_reg) && $signed(re) > lo_reg
                            && $signed(rg) < g_reg)
                            g_reg <= rg;
                        if ($signed(rs) > lo_reg || $signed(re) > lo_reg)
                            more_reg <= more_reg + gpet_pkg::PTC_W'(1);
                    end
                    idx_reg <= idx_reg + SW'(1);
                end
                gpet_pkg::BK_EMIT:
                begin
                    if (!res_v_reg)
                    begin
                        res_v_reg <= 1'b1;
                        res_reg <= {lo_reg, g_reg, (more_reg == '0), 1'b0, 1'b0};
                        best_v_reg <= 1'b0;
                        idx_reg <= '0;
                        half_reg <= 1'b0;
                        if (more_reg == '0)
                            lo_v_reg <= 1'b0;
                    end
                end
                gpet_pkg::BK_EMPTY:
                begin
                    if (!res_v_reg)
                    begin
                        res_v_reg <= 1'b1;
                        res_reg <= {32'd0, 11'd0, 1'b1, 1'b1, 1'b0};
                    end
                end
                gpet_pkg::BK_PRUNE:
                begin
                    if (valid_reg[idx_reg] && $signed(re) < cmd_reg.prune_pos)
                        valid_reg[idx_reg] <= 1'b0;
                    idx_reg <= idx_reg + SW'(1);
                end
                default: idx_reg <= idx_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == gpet_pkg::BK_IDLE && cmd_valid && cmd_ready)
            cmd_reg <= cmd;
    end

    `GPET_ASSERT_IMP(a_ready_idle, cmd_ready, st_reg == gpet_pkg::BK_IDLE)
    `GPET_ASSERT_NXT(a_empty_out, st_reg == gpet_pkg::BK_EMPTY && !res_v_reg,
        res_v_reg && res_reg[1])
    `GPET_ASSERT_IMP(a_no_write_on_recalc, st_reg == gpet_pkg::BK_SCAN, !we)
endmodule

// ===== tb/gradient_profile_envelope_table_test.sv =====
// self-checking testbench for the gradient envelope table
`timescale 1ns / 1ps
module gradient_profile_envelope_table_test;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic signed [31:0] pos;
        logic signed [10:0] grade;
        logic last;
        logic empty;
        logic ovf;
    } point_t;

    class envelope_scoreboard;
        logic signed [31:0] seg_lo [gpet_pkg::MAX_SEGMENTS];
        logic signed [31:0] seg_hi [gpet_pkg::MAX_SEGMENTS];
        logic signed [10:0] seg_gr [gpet_pkg::MAX_SEGMENTS];
        bit seg_used [gpet_pkg::MAX_SEGMENTS];
        logic signed [31:0] held_pos;
        logic signed [10:0] held_grade;
        bit held;
        gpet_pkg::batch_t batch;
        point_t expected_points [$];
        int errors;

        function void wipe();
            foreach (seg_used[i]) seg_used[i] = 0;
            held = 0;
            batch = gpet_pkg::BATCH_IDLE;
            expected_points.delete();
            errors = 0;
        endfunction

        function bit store(logic signed [31:0] s, logic signed [31:0] e,
                           logic signed [10:0] g);
            for (int i = 0; i < gpet_pkg::MAX_SEGMENTS; i++)
                if (!seg_used[i])
                begin
                    seg_lo[i] = s;
                    seg_hi[i] = e;
                    seg_gr[i] = g;
                    seg_used[i] = 1;
                    return 1;
                end
            return 0;
        endfunction

        function void push(logic signed [31:0] p, logic signed [10:0] g,
                           logic l, logic em, logic ov);
            point_t pt;
            pt.pos = p;
            pt.grade = g;
            pt.last = l;
            pt.empty = em;
            pt.ovf = ov;
            expected_points.insert(expected_points.size(), pt);
        endfunction

        function void build_envelope();
            logic signed [31:0] bounds [$];
            logic signed [31:0] v;
            logic signed [10:0] g;
            int b;
            int m;
            foreach (seg_used[i])
                if (seg_used[i])
                begin
                    bounds.insert(bounds.size(), seg_lo[i]);
                    bounds.insert(bounds.size(), seg_hi[i]);
                end
            if (bounds.size() == 0)
            begin
                push(0, 0, 1, 1, 0);
                return;
            end
            for (int a = 1; a < bounds.size(); a++)
            begin
                v = bounds[a];
                b = a - 1;
                while (b >= 0 && bounds[b] > v)
                begin
                    bounds[b + 1] = bounds[b];
                    b--;
                end
                bounds[b + 1] = v;
            end
            m = 0;
            for (int a = 0; a < bounds.size(); a++)
                if (m == 0 || bounds[m - 1] != bounds[a])
                begin
                    bounds[m] = bounds[a];
                    m++;
                end
            for (int k = 0; k < m; k++)
            begin
                g = gpet_pkg::GRADE_NONE;
                foreach (seg_used[i])
                    if (seg_used[i] && seg_lo[i] <= bounds[k] && seg_hi[i] > bounds[k]
                        && seg_gr[i] < g)
                        g = seg_gr[i];
                push(bounds[k], g, k == m - 1, 0, 0);
            end
        endfunction

        function void note_request(gpet_pkg::op_t op, logic signed [31:0] p,
                                   logic signed [10:0] g, logic fin);
            bit lost;
            lost = 0;
            case (op)
                gpet_pkg::OP_CLEAR:
                begin
                    foreach (seg_used[i]) seg_used[i] = 0;
                    held = 0;
                    batch = gpet_pkg::BATCH_IDLE;
                end
                gpet_pkg::OP_PRUNE:
                    foreach (seg_used[i])
                        if (seg_used[i] && seg_hi[i] < p) seg_used[i] = 0;
                gpet_pkg::OP_RECALC: build_envelope();
                default:
                begin
                    if (batch == gpet_pkg::BATCH_IDLE)
                    begin
                        foreach (seg_used[i])
                            if (seg_used[i])
                            begin
                                if (seg_lo[i] > p) seg_used[i] = 0;
                                else if (seg_hi[i] > p) seg_hi[i] = p;
                            end
                        held = 0;
                        batch = gpet_pkg::BATCH_OPEN;
                    end
                    if (batch == gpet_pkg::BATCH_OPEN)
                    begin
                        if (held)
                        begin
                            if (!store(held_pos, p, held_grade)) lost = 1;
                            held = 0;
                        end
                        if (g == gpet_pkg::GRADE_NONE)
                            batch = gpet_pkg::BATCH_DRAIN;
                        else
                        begin
                            held_pos = p;
                            held_grade = g;
                            held = 1;
                        end
                    end
                    if (fin)
                    begin
                        if (held)
                        begin
                            if (!store(held_pos, gpet_pkg::DIST_MAX, held_grade)) lost = 1;
                            held = 0;
                        end
                        batch = gpet_pkg::BATCH_IDLE;
                    end
                    if (lost) push(0, 0, 1, 0, 1);
                end
            endcase
        endfunction

        function void check_result(logic [gpet_pkg::RES_W-1:0] word);
            point_t got;
            point_t want;
            {got.pos, got.grade, got.last, got.empty, got.ovf} = word;
            if (expected_points.size() == 0)
            begin
                $error("unexpected result pos=%0d grade=%0d", got.pos, got.grade);
                errors++;
                return;
            end
            want = expected_points.pop_front();
            if (got.pos !== want.pos)
            begin
                $error("point_position expected %0d got %0d", want.pos, got.pos);
                errors++;
            end
            if (got.grade !== want.grade)
            begin
                $error("point_grade expected %0d got %0d", want.grade, got.grade);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last_of_run expected %0b got %0b", want.last, got.last);
                errors++;
            end
            if (got.empty !== want.empty)
            begin
                $error("table_empty expected %0b got %0b", want.empty, got.empty);
                errors++;
            end
            if (got.ovf !== want.ovf)
            begin
                $error("overflow expected %0b got %0b", want.ovf, got.ovf);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int cycles;
    int requests_sent;
    envelope_scoreboard envelope;

    gpet_stream_if #(.W(gpet_pkg::REQ_W)) req ();
    gpet_stream_if #(.W(gpet_pkg::RES_W)) res ();

    gradient_profile_envelope_table dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .res(res.source)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: random stalls plus one long hold-off once traffic is going
    initial
    begin
        bit held_off;
        int n;
        held_off = 0;
        res.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && requests_sent >= 60)
            begin
                held_off = 1;
                res.ready = 0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            n = gap_length();
            if (n > 0)
            begin
                res.ready = 0;
                repeat (n - 1) @(negedge clk);
            end
            else
                res.ready = 1;
        end
    end

    always @(posedge clk)
        if (rst_n && res.valid && res.ready) envelope.check_result(res.data);

    task automatic send(gpet_pkg::op_t op, logic signed [31:0] p, logic signed [10:0] g,
                        logic fin);
        int n;
        n = gap_length();
        if (n > 0)
        begin
            req.valid = 0;
            repeat (n) @(negedge clk);
        end
        req.valid = 1;
        req.data = {op, p, g, fin};
        do @(posedge clk); while (!req.ready);
        envelope.note_request(op, p, g, fin);
        requests_sent++;
        @(negedge clk);
        req.valid = 0;
    endtask

    function automatic logic signed [10:0] rand_grade();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 11'($urandom);
        if (roll == 1) return gpet_pkg::GRADE_NONE;
        return 11'($urandom_range(0, 510)) - 11'sd255;
    endfunction

    // well-formed batch of ascending points with random content
    task automatic send_batch(int count, logic signed [31:0] first, int max_step);
        logic signed [31:0] p;
        logic signed [10:0] g;
        p = first;
        for (int i = 0; i < count; i++)
        begin
            g = ($urandom_range(0, 15) == 0) ? gpet_pkg::GRADE_NONE : rand_grade();
            send(gpet_pkg::OP_LOAD, p, g, i == count - 1);
            p = p + $urandom_range(1, max_step);
        end
    endtask

    initial
    begin
        int roll;
        requests_sent = 0;
        envelope = new();
        envelope.wipe();
        rst_n = 0;
        req.valid = 0;
        req.data = '0;
        repeat (8) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed part
        send(gpet_pkg::OP_RECALC, 0, 0, 0);
        send(gpet_pkg::OP_LOAD, 32'sh80000000, -11'sd1024, 0);
        send(gpet_pkg::OP_LOAD, -32'sd5, 11'sd1023, 0);
        send(gpet_pkg::OP_LOAD, 32'sd100, 11'sd0, 1);
        send(gpet_pkg::OP_RECALC, 0, 0, 0);
        send(gpet_pkg::OP_LOAD, 32'sd50, gpet_pkg::GRADE_NONE, 0);
        send(gpet_pkg::OP_LOAD, 32'sd60, 11'sd7, 0);
        send(gpet_pkg::OP_LOAD, 32'sd70, 11'sd8, 1);
        send(gpet_pkg::OP_LOAD, 32'sd200, 11'sd3, 0);
        send(gpet_pkg::OP_LOAD, 32'sd150, 11'sd4, 1);
        send(gpet_pkg::OP_RECALC, 0, 0, 0);
        send(gpet_pkg::OP_PRUNE, 32'sd60, 0, 0);
        send(gpet_pkg::OP_RECALC, 0, 0, 0);
        send(gpet_pkg::OP_LOAD, 32'sd10, 11'sd2, 0);
        send(gpet_pkg::OP_CLEAR, 0, 0, 0);
        send(gpet_pkg::OP_LOAD, gpet_pkg::DIST_MAX, 11'sd1, 1);
        send(gpet_pkg::OP_RECALC, 0, 0, 0);
        send(gpet_pkg::OP_PRUNE, gpet_pkg::DIST_MAX, 0, 0);
        send(gpet_pkg::OP_PRUNE, 32'sh80000000, 0, 0);
        send(gpet_pkg::OP_RECALC, 0, 0, 0);
        send(gpet_pkg::OP_CLEAR, 0, 0, 0);
        // overflow: one batch longer than the table
        send_batch(gpet_pkg::MAX_SEGMENTS + 2, -32'sd1000, 40);
        send(gpet_pkg::OP_RECALC, 0, 0, 0);

        // random part
        while (requests_sent < 270)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
                send_batch($urandom_range(1, 6), $urandom_range(0, 1) ?
                           $signed($urandom) : $signed($urandom_range(0, 4000)),
                           $urandom_range(0, 1) ? 500 : 100000);
            else if (roll < 65)
                send(gpet_pkg::OP_RECALC, $urandom, 11'($urandom), 1'($urandom));
            else if (roll < 75)
                send(gpet_pkg::OP_PRUNE, $urandom_range(0, 1) ? $signed($urandom) :
                     $signed($urandom_range(0, 4000)), 11'($urandom), 1'($urandom));
            else if (roll < 80)
                send(gpet_pkg::OP_CLEAR, $urandom, 11'($urandom), 1'($urandom));
            else
                send(gpet_pkg::OP_LOAD, $urandom, rand_grade(), 1'($urandom_range(0, 1)));
        end
        send(gpet_pkg::OP_LOAD, 0, 0, 1);
        send(gpet_pkg::OP_RECALC, 0, 0, 0);

        while (envelope.expected_points.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (envelope.expected_points.size() != 0)
        begin
            $error("%0d expected results never arrived", envelope.expected_points.size());
            envelope.errors++;
        end
        if (envelope.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
